// ===== design/bht_pkg.sv =====
// Package for the bucket hash table: default sizes, opcodes and status codes.
// Used by the top level and the bucket sequencer.
`default_nettype none
package bht_pkg;
  localparam int unsigned PrimaryBuckets  = 16;
  localparam int unsigned OverflowBuckets = 4;
  localparam int unsigned SlotsPerBucket  = 4;
  localparam int unsigned PayloadBits     = 32;
  localparam int unsigned KeyW            = 27;
  localparam int unsigned OutPayW         = 32;
  localparam int unsigned CountW          = 8;
  localparam logic [CountW-1:0] CountMax  = 8'd255;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_PRIMARY  = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_MISS     = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== design/bht_seq.sv =====
// Bucket sequencer: walks the count memory and the slot memory for one command.
// Depends on bht_pkg for codes and default sizes.
`default_nettype none
module bht_seq #(
  parameter int unsigned PRIMARY_BUCKETS  = bht_pkg::PrimaryBuckets,
  parameter int unsigned OVERFLOW_BUCKETS = bht_pkg::OverflowBuckets,
  parameter int unsigned SLOTS_PER_BUCKET = bht_pkg::SlotsPerBucket,
  parameter int unsigned PAYLOAD_BITS     = bht_pkg::PayloadBits
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       operation,
  input  wire logic [bht_pkg::KeyW-1:0]   key,
  input  wire logic [PAYLOAD_BITS-1:0]    payload,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [4:0]                      bucket,
  output logic [bht_pkg::OutPayW-1:0]     found_payload
);
  localparam int unsigned TotalBuckets = PRIMARY_BUCKETS + OVERFLOW_BUCKETS;
  localparam int unsigned BW = (TotalBuckets > 1) ? $clog2(TotalBuckets) : 1;
  localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned SlotDepth = TotalBuckets * SLOTS_PER_BUCKET;
  localparam int unsigned AW = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int unsigned KW = bht_pkg::KeyW;
  localparam int unsigned CW = bht_pkg::CountW;
  localparam int unsigned HW = (PRIMARY_BUCKETS > 1) ? $clog2(PRIMARY_BUCKETS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_HASH  = 8'b00000010,
    S_CRD   = 8'b00000100,
    S_CEVAL = 8'b00001000,
    S_SRD   = 8'b00010000,
    S_SEVAL = 8'b00100000,
    S_HBUMP = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;
  logic [CW-1:0]  count_mem [TotalBuckets];
  logic [TotalBuckets-1:0] count_valid;
  logic [KW+PAYLOAD_BITS-1:0] slot_mem [SlotDepth];

  logic            op;
  logic [KW-1:0]   k;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [BW-1:0]   home;
  logic [BW-1:0]   cur;
  logic [SW:0]     slot;
  logic [SW:0]     used;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   cnt_raw;
  logic [KW+PAYLOAD_BITS-1:0] slot_q;
  logic            in_ovf;

  // Hash: key modulo the primary bucket count, a mask for powers of two.
  logic [KW-1:0] hash_full;
  assign hash_full = k % KW'(PRIMARY_BUCKETS);

  // Count word as read; entries never written read as zero.
  logic [CW-1:0] cnt;
  assign cnt = cnt_q;

  logic [CW-1:0] cnt_inc;
  assign cnt_inc = (cnt == bht_pkg::CountMax) ? cnt : cnt + CW'(1);

  logic room;
  assign room = cnt < CW'(SLOTS_PER_BUCKET);

  logic [SW:0] used_c;
  assign used_c = room ? cnt[SW:0] : (SW+1)'(SLOTS_PER_BUCKET);

  logic [AW-1:0] slot_addr;
  assign slot_addr = AW'(cur * SLOTS_PER_BUCKET) + AW'(slot[SW-1:0]);
  logic [AW-1:0] put_addr;
  assign put_addr = AW'(cur * SLOTS_PER_BUCKET) + AW'(cnt[SW-1:0]);

  logic last_ovf;
  assign last_ovf = (cur == BW'(TotalBuckets - 1));

  logic [PAYLOAD_BITS-1:0] slot_pay;
  assign slot_pay = slot_q[PAYLOAD_BITS-1:0];

  // Count memory write port and slot memory write port, driven by the sequencer.
  logic          cwe;
  logic [BW-1:0] cwa;
  logic [CW-1:0] cwd;
  logic          swe;

  always_comb begin
    cwe = 1'b0;
    cwa = cur;
    cwd = cnt_inc;
    swe = 1'b0;
    if (state == S_CEVAL && op == bht_pkg::OP_INSERT) begin
      if (room) begin
        cwe = 1'b1;
        swe = 1'b1;
      end else if (in_ovf) begin
        cwe = 1'b1;
      end
    end
    if (state == S_HBUMP) begin
      cwe = 1'b1;
      cwa = home;
      cwd = (cnt == bht_pkg::CountMax) ? cnt : cnt + CW'(1);
    end
  end

  // Memories: one read per cycle, registered data.
  always_ff @(posedge clk) begin
    if (cwe) count_mem[cwa] <= cwd;
    cnt_raw <= count_mem[cur];
    if (swe) slot_mem[put_addr] <= {k, pay};
    slot_q <= slot_mem[slot_addr];
  end

  logic cvalid_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= '0;
    end else if (cwe) begin
      count_valid[cwa] <= 1'b1;
    end
  end
  always_ff @(posedge clk) cvalid_q <= count_valid[cur];
  assign cnt_q = cvalid_q ? cnt_raw : '0;

  // Second pass of an overflow insert: the home count is re-read and bumped.
  logic status_hold;
  logic hb;
  always_ff @(posedge clk) begin
    if (rst) hb <= 1'b0;
    else if (state == S_CEVAL && op == bht_pkg::OP_INSERT && room && in_ovf) hb <= 1'b1;
    else if (state == S_HBUMP) hb <= 1'b0;
  end
  assign status_hold = hb;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op    <= operation;
            k     <= key;
            pay   <= payload;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          home   <= BW'(hash_full[HW-1:0]);
          cur    <= BW'(hash_full[HW-1:0]);
          in_ovf <= 1'b0;
          state  <= S_CRD;
        end
        S_CRD: state <= S_CEVAL;
        S_CEVAL: begin
          // The result of an overflow insert is kept through the home count bump.
          if (!status_hold) begin
            status        <= bht_pkg::ST_MISS;
            bucket        <= '0;
            found_payload <= '0;
          end
          if (op == bht_pkg::OP_INSERT) begin
            if (room) begin
              status <= in_ovf ? bht_pkg::ST_OVERFLOW : bht_pkg::ST_PRIMARY;
              bucket <= 5'(cur);
              if (in_ovf) begin
                cur   <= home;
                state <= S_CRD;
                in_ovf <= 1'b0;
                op    <= bht_pkg::OP_SEARCH;
              end else begin
                state <= S_DONE;
              end
            end else if (!in_ovf || !last_ovf) begin
              cur    <= in_ovf ? cur + BW'(1) : BW'(PRIMARY_BUCKETS);
              in_ovf <= 1'b1;
              state  <= S_CRD;
            end else begin
              state <= S_DONE;
            end
          end else if (status_hold) begin
            state <= S_HBUMP;
          end else if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            used  <= used_c;
            slot  <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SEVAL;
        S_SEVAL: begin
          if (slot_q[KW+PAYLOAD_BITS-1:PAYLOAD_BITS] == k) begin
            status        <= in_ovf ? bht_pkg::ST_OVERFLOW : bht_pkg::ST_PRIMARY;
            bucket        <= 5'(cur);
            found_payload <= bht_pkg::OutPayW'(slot_pay);
            state         <= S_DONE;
          end else if (slot + (SW+1)'(1) < used) begin
            slot  <= slot + (SW+1)'(1);
            state <= S_SRD;
          end else if ((!in_ovf && used == (SW+1)'(SLOTS_PER_BUCKET)) ||
                       (in_ovf && !last_ovf)) begin
            cur    <= in_ovf ? cur + BW'(1) : BW'(PRIMARY_BUCKETS);
            in_ovf <= 1'b1;
            state  <= S_CRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_HBUMP: state <= S_DONE;
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a command in flight");
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    done && status == bht_pkg::ST_MISS |-> bucket == '0 && found_payload == '0)
    else $error("miss result carries data");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command not taken");
`endif
endmodule
`default_nettype wire

// ===== design/bucket_hash_table_with_overflow_unit.sv =====
// Top level of the bucket hash table with a shared overflow area.
// Depends on bht_pkg and bht_seq.
//
// A command is taken at a rising edge when start is high and busy is low;
// exactly one result follows, on the result ports for one cycle with done
// high, and the receiver cannot hold it off. busy stays high through hashing
// and the home count read, each slot compared, each overflow bucket visited
// with its slots compared, the home count bump after an insert that lands in
// overflow, and a closing state. done rises in the same cycle that busy
// falls, and that cycle can already take the next command. The count and
// slot memories each have a single read port.
`default_nettype none
module bucket_hash_table_with_overflow_unit #(
  parameter int unsigned PRIMARY_BUCKETS  = bht_pkg::PrimaryBuckets,
  parameter int unsigned OVERFLOW_BUCKETS = bht_pkg::OverflowBuckets,
  parameter int unsigned SLOTS_PER_BUCKET = bht_pkg::SlotsPerBucket,
  parameter int unsigned PAYLOAD_BITS     = bht_pkg::PayloadBits
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       operation,
  input  wire logic [bht_pkg::KeyW-1:0]   key,
  input  wire logic [PAYLOAD_BITS-1:0]    payload,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [4:0]                      bucket,
  output logic [bht_pkg::OutPayW-1:0]     found_payload
);
  bht_seq #(
    .PRIMARY_BUCKETS (PRIMARY_BUCKETS),
    .OVERFLOW_BUCKETS(OVERFLOW_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .PAYLOAD_BITS    (PAYLOAD_BITS)
  ) u_seq (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key(key), .payload(payload),
    .done(done), .status(status), .bucket(bucket), .found_payload(found_payload)
  );
endmodule
`default_nettype wire
